// ===== rtl/core/plst_pkg.sv =====
`default_nettype none

package plst_pkg;

    // Fixed field widths of the request and response channels
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CNTO_W = 5;
    localparam int STAT_W = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [VAL_W-1:0]  t_word;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [CNTO_W-1:0] t_cnt_out;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_ERASE  = 2'd1;
    localparam t_op OP_GET    = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic ers;
        t_pos pos;
    } t_cell_ctl;

    // Outcome of one request, from the decoder to the response register
    typedef struct packed {
        logic    rd_en;
        t_status status;
    } t_op_res;

endpackage

`default_nettype wire

// ===== rtl/core/plst_if.sv =====
`default_nettype none

interface plst_req_if import plst_pkg::*; ();
    logic  valid;
    logic  ready;
    t_op   op;
    t_pos  pos;
    t_word value;

    modport source (output valid, output op, output pos, output value, input ready);
    modport sink   (input valid, input op, input pos, input value, output ready);
endinterface

interface plst_rsp_if import plst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_word    read_data;
    t_status  status;
    t_cnt_out entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/positional_list_store.sv =====
`default_nettype none

// Channel   Dir  Fields                               Meaning
// i_req     in   op, pos, value                       insert / erase / get request
// o_rsp     out  read_data, status, entry_count       one response per request
//
// One request per clock while o_rsp is not stalled: a request is decoded and applied
// to the whole row of cells in the cycle it is accepted, and its response is registered.
// Every cell compares its index with pos and shifts toward its neighbor in parallel.
// The response register frees i_req.ready whenever it is empty or being drained,
// so a stalled o_rsp holds exactly one response and stalls i_req.
// Synchronous active-low reset clears the entry count and the response valid;
// stored words stay undefined until written.
module positional_list_store import plst_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    plst_req_if.sink  i_req,
    plst_rsp_if.source o_rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SLOTS  = 1 << POS_W;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_valid;
    t_word                 r_read_data;
    t_status               r_status;
    t_cnt_out              r_entry_count;

    logic                  accept;
    t_cell_ctl             cell_ctl;
    t_op_res               op_res;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] ins_value;
    t_word                 slot [SLOTS];
    t_word                 rd_word;

    // Take a request whenever the response register is free or draining
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign ins_value   = DATA_WIDTH'(i_req.value);

    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .CMP_W    (CMP_W)
    ) u_ctrl (
        .i_go    (accept),
        .i_op    (i_req.op),
        .i_pos   (i_req.pos),
        .i_count (r_count),
        .o_ctl   (cell_ctl),
        .o_res   (op_res),
        .o_count (n_count)
    );

    // Row of cells: cell k holds entry k; inserts pull from k-1, erases from k+1
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[k+1];
        end

        plst_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_left  (left),
            .i_right (right),
            .i_value (ins_value),
            .o_data  (cell_data[k])
        );
    end

    // Only the first SLOTS positions are addressable by pos
    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        if (s < CAPACITY) begin : g_held
            assign slot[s] = VAL_W'(cell_data[s]);
        end else begin : g_none
            assign slot[s] = '0;
        end
    end

    assign rd_word = op_res.rd_en ? slot[i_req.pos] : '0;

    // Count and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Response payload: hold until the next request is taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data   <= rd_word;
            r_status      <= op_res.status;
            r_entry_count <= CNTO_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.read_data   = r_read_data;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

endmodule

`default_nettype wire

// ===== rtl/core/plst_cell.sv =====
`default_nettype none

module plst_cell import plst_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    output logic      [DATA_WIDTH-1:0] o_data
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CMP_W-1:0]      pos_ext;

    assign pos_ext = CMP_W'(i_ctl.pos);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            // take the neighbor in front when behind the slot, the new word at it
            if (IDX > pos_ext) begin
                n_data = i_left;
            end else if (IDX == pos_ext) begin
                n_data = i_value;
            end
        end else if (i_ctl.ers) begin
            if (IDX >= pos_ext) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/plst_ctrl.sv =====
`default_nettype none

module plst_ctrl import plst_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5,
    parameter int CMP_W    = 5
) (
    input  wire logic             i_go,
    input  wire t_op              i_op,
    input  wire t_pos             i_pos,
    input  wire logic [CNT_W-1:0] i_count,
    output t_cell_ctl             o_ctl,
    output t_op_res               o_res,
    output logic      [CNT_W-1:0] o_count
);

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;

    assign pos_ext = CMP_W'(i_pos);
    assign cnt_ext = CMP_W'(i_count);
    assign full    = (i_count >= CNT_W'(CAPACITY));

    always_comb begin
        o_ctl.ins    = 1'b0;
        o_ctl.ers    = 1'b0;
        o_ctl.pos    = i_pos;
        o_res.rd_en  = 1'b0;
        o_res.status = ST_OK;
        o_count      = i_count;
        unique case (i_op)
            OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    o_res.status = ST_RANGE;
                end else if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_ctl.ins = i_go;
                    o_count   = i_count + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (pos_ext >= cnt_ext) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_ctl.ers = i_go;
                    o_count   = i_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (pos_ext >= cnt_ext) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_res.rd_en = 1'b1;
                end
            end
            default: begin
                o_res.status = ST_RANGE;
            end
        endcase
    end

endmodule

`default_nettype wire
